// ===== hw/rtl/dtsf_pkg.sv =====
package dtsf_pkg;

   // Request command codes
   typedef enum logic [1:0] {
      CMD_BYTE   = 2'd0,
      CMD_RENDER = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Fixed field widths
   localparam int ROW_W   = 3;   // ring row number, up to 8 rows
   localparam int COL_W   = 4;   // cell column index, up to 16 columns
   localparam int CURC_W  = 5;   // column cursor, can reach COLS itself
   localparam int WIDX_W  = 7;   // write index cursor
   localparam int CODE_W  = 4;   // cell code
   localparam int BYTE_W  = 8;
   localparam int STEP_W  = 3;   // draw step within one cell

   // Cell codes and serial characters
   localparam logic [CODE_W-1:0] BLANK_CODE = 4'd11;
   localparam logic [CODE_W-1:0] LAST_DIGIT = 4'd9;
   localparam logic [CODE_W-1:0] DIGIT_ONE  = 4'd1;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   // Screen geometry: cell center = ORIGIN + ROW_STRIDE*row - CELL_STRIDE*col
   localparam int ORIGIN      = 290 + 60 - 256;
   localparam int ROW_STRIDE  = 128;
   localparam int CELL_STRIDE = 4;
   localparam int HALF_SPAN   = 2;   // glyph reaches center+2 down to center-2
   localparam int LAST_STEP   = 4;   // five draw steps per cell
   localparam int CENTER_STEP = 2;

   // Text grid control from the sequencer
   typedef struct packed {
      logic                   byte_en;
      logic [BYTE_W-1:0]      byte_val;
      logic                   rd_en;
      logic [ROW_W-1:0]       rd_row;
      logic [COL_W-1:0]       rd_col;
   } grid_req_type;

   // Text grid status back to the sequencer
   typedef struct packed {
      logic [CODE_W-1:0]      code;
      logic [ROW_W-1:0]       head_row;
   } grid_rsp_type;

   // 3x5 digit font; col 0 lands at center+1, col 2 at center-1
   function automatic logic [BYTE_W-1:0] font_col(input logic [CODE_W-1:0] code,
                                                  input logic [1:0] col);
      logic [4:0] c0;
      logic [4:0] c1;
      logic [4:0] c2;
      logic [4:0] sel;
      c0 = 5'h00;
      c1 = 5'h00;
      c2 = 5'h00;
      unique case (code)
         4'd0:    begin c0 = 5'h1F; c1 = 5'h11; c2 = 5'h1F; end
         4'd1:    begin c0 = 5'h10; c1 = 5'h1F; c2 = 5'h00; end
         4'd2:    begin c0 = 5'h17; c1 = 5'h15; c2 = 5'h1D; end
         4'd3:    begin c0 = 5'h15; c1 = 5'h15; c2 = 5'h1F; end
         4'd4:    begin c0 = 5'h1C; c1 = 5'h04; c2 = 5'h1F; end
         4'd5:    begin c0 = 5'h1D; c1 = 5'h15; c2 = 5'h17; end
         4'd6:    begin c0 = 5'h1F; c1 = 5'h05; c2 = 5'h07; end
         4'd7:    begin c0 = 5'h10; c1 = 5'h10; c2 = 5'h1F; end
         4'd8:    begin c0 = 5'h1F; c1 = 5'h15; c2 = 5'h1F; end
         4'd9:    begin c0 = 5'h1C; c1 = 5'h14; c2 = 5'h1F; end
         default: begin c0 = 5'h00; c1 = 5'h00; c2 = 5'h00; end
      endcase
      unique case (col)
         2'd0:    sel = c0;
         2'd1:    sel = c1;
         default: sel = c2;
      endcase
      return {3'b000, sel};
   endfunction

endpackage

// ===== hw/rtl/dtsf_frame_mem.sv =====
module dtsf_frame_mem #(
   parameter int AW = 10,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dtsf_text_grid.sv =====
module dtsf_text_grid #(
   parameter int ROWS = 6,
   parameter int COLS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dtsf_pkg::grid_req_type ctl,
   output dtsf_pkg::grid_rsp_type sts
);

   localparam int CELLS   = ROWS * COLS;
   localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic [dtsf_pkg::CODE_W-1:0] mem [CELLS];
   logic [CELLS-1:0]            valid_ff, valid_in;
   logic [dtsf_pkg::ROW_W-1:0]  head_row_ff, head_row_in;
   logic [dtsf_pkg::CURC_W-1:0] column_ff, column_in;
   logic [dtsf_pkg::WIDX_W-1:0] write_index_ff, write_index_in;
   logic [dtsf_pkg::CODE_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   logic                        is_nl;
   logic                        is_digit;
   logic                        is_space;
   logic                        col_open;
   logic                        idx_ok;
   logic                        cell_we;
   logic [dtsf_pkg::CODE_W-1:0] cell_wdata;
   logic [CELL_AW-1:0]          wr_idx;
   logic [CELL_AW-1:0]          rd_idx;
   logic [dtsf_pkg::ROW_W-1:0]  next_row;
   logic [dtsf_pkg::WIDX_W-1:0] row_base;

   // Decode the serial byte
   assign is_nl    = ctl.byte_en && (ctl.byte_val == dtsf_pkg::CHAR_NL);
   assign is_digit = (ctl.byte_val >= dtsf_pkg::CHAR_ZERO) &&
                     (ctl.byte_val <= dtsf_pkg::CHAR_NINE);
   assign is_space = (ctl.byte_val == dtsf_pkg::CHAR_SPACE);
   assign col_open = int'(column_ff) < COLS;
   assign idx_ok   = int'(write_index_ff) < CELLS;
   assign cell_we  = ctl.byte_en && !is_nl && col_open && idx_ok && (is_digit || is_space);
   assign cell_wdata = is_digit ? ctl.byte_val[dtsf_pkg::CODE_W-1:0] : dtsf_pkg::BLANK_CODE;
   assign wr_idx   = write_index_ff[CELL_AW-1:0];
   assign rd_idx   = CELL_AW'(int'(ctl.rd_row) * COLS + int'(ctl.rd_col));

   // Next ring row and its first cell
   assign next_row = (int'(head_row_ff) == ROWS - 1) ? '0
                     : head_row_ff + dtsf_pkg::ROW_W'(1);
   assign row_base = dtsf_pkg::WIDX_W'(int'(next_row) * COLS);

   // Cursor update
   always_comb begin
      head_row_in    = head_row_ff;
      column_in      = column_ff;
      write_index_in = write_index_ff;
      if (is_nl) begin
         head_row_in    = next_row;
         column_in      = '0;
         write_index_in = row_base;
      end else if (ctl.byte_en && col_open) begin
         column_in      = column_ff + dtsf_pkg::CURC_W'(1);
         write_index_in = write_index_ff + dtsf_pkg::WIDX_W'(1);
      end
   end

   // Valid bits: a newline blanks the new row, a stored cell becomes valid
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < CELLS; i++) begin
         if (is_nl && (i >= int'(row_base)) && (i < int'(row_base) + COLS)) begin
            valid_in[i] = 1'b0;
         end else if (cell_we && (int'(wr_idx) == i)) begin
            valid_in[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         head_row_ff    <= '0;
         column_ff      <= '0;
         write_index_ff <= '0;
      end else begin
         valid_ff       <= valid_in;
         head_row_ff    <= head_row_in;
         column_ff      <= column_in;
         write_index_ff <= write_index_in;
      end
   end

   // Cell memory, registered read for the renderer
   always_ff @(posedge clock) begin
      if (cell_we) begin
         mem[wr_idx] <= cell_wdata;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   // A cell never written since its row was cleared reads blank
   assign sts.code     = rd_valid_ff ? rd_data_ff : dtsf_pkg::BLANK_CODE;
   assign sts.head_row = head_row_ff;

endmodule

// ===== hw/rtl/digit_text_scroller_framebuffer_unit.sv =====
// Text scroller with a ROWS x COLS digit grid and a FB_BYTES frame buffer.
// After reset the block clears the frame buffer one byte a cycle, with
// req_stall high. A serial byte (command 0) is taken in the idle state.
// A frame buffer read (command 2) passes the registered read port and
// ST_LOAD; its result sits in an output register until taken, while byte
// and render requests keep flowing. In a render (command 1) each cell
// costs one cell-store read plus five glyph steps through the single
// frame buffer write port, with one shared adder stepping the write
// address. Requests stall while a render or a read runs.
module digit_text_scroller_framebuffer_unit #(
   parameter int ROWS     = 6,
   parameter int COLS     = 16,
   parameter int FB_BYTES = 1024,
   localparam int FB_AW   = $clog2(FB_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_command,
   input  logic [7:0]       req_byte_in,
   input  logic [FB_AW-1:0] req_read_address,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_read_data
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_DRAW  = 5'b01000,
      ST_LOAD  = 5'b10000
   } state_type;

   localparam logic [FB_AW-1:0] TOP_START =
      FB_AW'(dtsf_pkg::ORIGIN + dtsf_pkg::HALF_SPAN);
   localparam logic [FB_AW-1:0] ADD_ROW  = FB_AW'(dtsf_pkg::ROW_STRIDE);
   localparam logic [FB_AW-1:0] SUB_CELL = FB_AW'(FB_BYTES - dtsf_pkg::CELL_STRIDE);
   localparam logic [FB_AW-1:0] SUB_ONE  = FB_AW'(FB_BYTES - 1);

   state_type                   state_ff, state_in;
   logic [FB_AW-1:0]            clr_ff, clr_in;
   logic [dtsf_pkg::ROW_W-1:0]  scr_row_ff, scr_row_in;
   logic [dtsf_pkg::ROW_W-1:0]  ring_ff, ring_in;
   logic [dtsf_pkg::COL_W-1:0]  col_ff, col_in;
   logic [dtsf_pkg::STEP_W-1:0] step_ff, step_in;
   logic [FB_AW-1:0]            row_top_ff, row_top_in;
   logic [FB_AW-1:0]            cell_top_ff, cell_top_in;
   logic [FB_AW-1:0]            draw_addr_ff, draw_addr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_data_ff, rsp_data_in;

   dtsf_pkg::grid_req_type      grid_ctl;
   dtsf_pkg::grid_rsp_type      grid_sts;

   logic                        accept;
   logic                        last_col;
   logic                        last_row;
   logic                        last_step;
   logic                        can_load;
   logic [FB_AW-1:0]            add_a, add_b, add_sum;
   logic                        fb_we;
   logic [FB_AW-1:0]            fb_waddr;
   logic [7:0]                  fb_wdata;
   logic                        fb_re;
   logic [7:0]                  fb_rdata;
   logic                        glyph_we;
   logic [7:0]                  glyph_data;
   logic                        code_digit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign last_col  = (int'(col_ff) == COLS - 1);
   assign last_row  = (int'(scr_row_ff) == ROWS - 1);
   assign last_step = (int'(step_ff) == dtsf_pkg::LAST_STEP);
   assign can_load  = !rsp_valid_ff || !rsp_stall;

   // Shared address adder: step down within a cell, move to next cell or row
   always_comb begin
      add_a = '0;
      add_b = '0;
      if (state_ff == ST_DRAW) begin
         if (!last_step) begin
            add_a = draw_addr_ff;
            add_b = SUB_ONE;
         end else if (last_col) begin
            add_a = row_top_ff;
            add_b = ADD_ROW;
         end else begin
            add_a = cell_top_ff;
            add_b = SUB_CELL;
         end
      end
   end
   assign add_sum = add_a + add_b;

   // Glyph byte for the current draw step
   always_comb begin
      code_digit = (grid_sts.code <= dtsf_pkg::LAST_DIGIT);
      glyph_we   = 1'b1;
      glyph_data = '0;
      if (code_digit) begin
         glyph_we   = (step_ff != '0) && !last_step &&
                      !((int'(step_ff) == dtsf_pkg::LAST_STEP - 1) &&
                        (grid_sts.code == dtsf_pkg::DIGIT_ONE));
         glyph_data = dtsf_pkg::font_col(grid_sts.code, 2'(step_ff - 3'd1));
      end else begin
         glyph_data = (int'(step_ff) == dtsf_pkg::CENTER_STEP) ? 8'd1 : 8'd0;
      end
   end

   // Frame buffer port selection
   always_comb begin
      fb_we    = 1'b0;
      fb_waddr = draw_addr_ff;
      fb_wdata = glyph_data;
      if (state_ff == ST_CLEAR) begin
         fb_we    = 1'b1;
         fb_waddr = clr_ff;
         fb_wdata = '0;
      end else if (state_ff == ST_DRAW) begin
         fb_we = glyph_we;
      end
   end
   assign fb_re = accept && (req_command == dtsf_pkg::CMD_READ);

   // Text grid control
   always_comb begin
      grid_ctl          = '0;
      grid_ctl.byte_en  = accept && (req_command == dtsf_pkg::CMD_BYTE);
      grid_ctl.byte_val = req_byte_in;
      grid_ctl.rd_en    = (state_ff == ST_FETCH);
      grid_ctl.rd_row   = ring_ff;
      grid_ctl.rd_col   = col_ff;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scr_row_in   = scr_row_ff;
      ring_in      = ring_ff;
      col_in       = col_ff;
      step_in      = step_ff;
      row_top_in   = row_top_ff;
      cell_top_in  = cell_top_ff;
      draw_addr_in = draw_addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + FB_AW'(1);
            if (int'(clr_ff) == FB_BYTES - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (dtsf_pkg::cmd_type'(req_command))
                  dtsf_pkg::CMD_RENDER: begin
                     state_in    = ST_FETCH;
                     scr_row_in  = '0;
                     col_in      = '0;
                     ring_in     = grid_sts.head_row;
                     row_top_in  = TOP_START;
                     cell_top_in = TOP_START;
                  end
                  dtsf_pkg::CMD_READ: begin
                     state_in = ST_LOAD;
                  end
                  dtsf_pkg::CMD_BYTE,
                  dtsf_pkg::CMD_NONE: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            draw_addr_in = cell_top_ff;
            step_in      = '0;
            state_in     = ST_DRAW;
         end
         ST_DRAW: begin
            if (!last_step) begin
               step_in      = step_ff + dtsf_pkg::STEP_W'(1);
               draw_addr_in = add_sum;
            end else begin
               cell_top_in = add_sum;
               state_in    = ST_FETCH;
               if (last_col) begin
                  row_top_in = add_sum;
                  col_in     = '0;
                  scr_row_in = scr_row_ff + dtsf_pkg::ROW_W'(1);
                  ring_in    = (ring_ff == '0) ? dtsf_pkg::ROW_W'(ROWS - 1)
                               : ring_ff - dtsf_pkg::ROW_W'(1);
                  if (last_row) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  col_in = col_ff + dtsf_pkg::COL_W'(1);
               end
            end
         end
         ST_LOAD: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fb_rdata;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scr_row_ff   <= scr_row_in;
      ring_ff      <= ring_in;
      col_ff       <= col_in;
      step_ff      <= step_in;
      row_top_ff   <= row_top_in;
      cell_top_ff  <= cell_top_in;
      draw_addr_ff <= draw_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   dtsf_text_grid #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_grid (
      .clock (clock),
      .reset (reset),
      .ctl   (grid_ctl),
      .sts   (grid_sts)
   );

   dtsf_frame_mem #(
      .AW (FB_AW),
      .DW (8)
   ) u_fb (
      .clock   (clock),
      .wr_en   (fb_we),
      .wr_addr (fb_waddr),
      .wr_data (fb_wdata),
      .rd_en   (fb_re),
      .rd_addr (req_read_address),
      .rd_data (fb_rdata)
   );

endmodule
